// File: hw/rtl/litr_pkg.sv
package litr_pkg;

    localparam int unsigned OffW   = 12;
    localparam int unsigned WordW  = 32;
    localparam int unsigned VecW   = 8;
    localparam int unsigned CfgW   = 8;
    localparam int unsigned CfgIdxW = 1;
    localparam int unsigned PreW   = 7;
    localparam int unsigned InDataW  = 48;
    localparam int unsigned OutDataW = 48;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_UNIT_ID = 1'b0,
        CFG_VERSION = 1'b1
    } t_cfg_idx;

    localparam logic [OffW-1:0] OFF_ID       = 12'h020;
    localparam logic [OffW-1:0] OFF_VERSION  = 12'h030;
    localparam logic [OffW-1:0] OFF_EOI      = 12'h0b0;
    localparam logic [OffW-1:0] OFF_SPURIOUS = 12'h0f0;
    localparam logic [OffW-1:0] OFF_LVT      = 12'h320;
    localparam logic [OffW-1:0] OFF_INITIAL  = 12'h380;
    localparam logic [OffW-1:0] OFF_CURRENT  = 12'h390;
    localparam logic [OffW-1:0] OFF_DIVIDE   = 12'h3e0;

    localparam int unsigned LVT_MASK_BIT     = 16;
    localparam int unsigned LVT_PERIODIC_BIT = 17;
    localparam int unsigned SW_ENABLE_BIT    = 8;
    localparam logic [3:0]  DIVIDE_BITS      = 4'b1011;
    localparam logic [3:0]  DIVIDE_RESET     = 4'b0000;
    localparam logic [VecW-1:0] VERSION_RESET = 8'd20;

    // code bits 3,1,0 -> divide by 2..128, or by 1 when all three are set
    function automatic logic [PreW:0] divisor_of(logic [3:0] code);
        logic [2:0] sel;
        sel = {code[3], code[1:0]};
        if (sel == 3'd7) begin
            return 8'd1;
        end
        return 8'd2 << sel;
    endfunction

endpackage

// File: hw/rtl/local_interrupt_timer_registers.sv
// Local interrupt-controller timer, register view.
// Input stream (s side): each item is a register read, a register write or one
// timer clock tick; tuser carries the opcode, tdata the offset and write data.
// Output stream (m side): exactly one result item per input item, carrying read
// data (zero for writes and ticks) and any interrupt delivered with that item.
// The result is registered; it waits in the skid register if the receiver
// stalls. Throughput: one item per cycle while tready is high; the register
// state is updated in the accept cycle so the next item sees it immediately.
// A two-entry output buffer (result register plus skid register) lets the
// block keep accepting one more item while the receiver stalls; tready drops
// only once both entries are full and rises again when the receiver takes one.
// Configuration (unit id, version) is written through the plain write port;
// the user must do so only while the block is idle; the block does not enforce it.
// Reset (synchronous, active low) empties the output buffer and returns all
// timer registers to their reset values: LVT masked and one-shot, counters
// stopped, divide by two, software disabled, spurious vector all ones.
module local_interrupt_timer_registers (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [litr_pkg::CfgIdxW-1:0]       i_cfg_addr,
    input  logic [litr_pkg::CfgW-1:0]          i_cfg_data,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // tdata: reg_offset[11:0], write_data[43:12], zero fill
    input  logic [litr_pkg::InDataW-1:0]       i_s_tdata,
    // tuser: opcode[1:0]
    input  logic [1:0]                         i_s_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // tdata: read_data[31:0], irq_valid[32], irq_vector[40:33], zero fill
    output logic [litr_pkg::OutDataW-1:0]      o_m_tdata
);
    import litr_pkg::*;

    localparam int unsigned ResW = WordW + 1 + VecW;

    logic [CfgW-1:0]  r_unit_id, r_version;
    logic [VecW-1:0]  r_lvt_vector, n_lvt_vector;
    logic             r_lvt_masked, n_lvt_masked;
    logic             r_lvt_periodic, n_lvt_periodic;
    logic [WordW-1:0] r_initial, n_initial;
    logic [WordW-1:0] r_current, n_current;
    logic [3:0]       r_divide, n_divide;
    logic [PreW-1:0]  r_prescale, n_prescale;
    logic             r_sw_enable, n_sw_enable;
    logic [VecW-1:0]  r_spurious, n_spurious;
    logic             r_in_service, n_in_service;
    logic             r_held, n_held;

    logic             r_out_valid, r_skid_valid;
    logic [ResW-1:0]  r_out, r_skid;

    t_opcode          opcode;
    logic [OffW-1:0]  offset;
    logic [WordW-1:0] wdata;
    logic             accept;
    logic [WordW-1:0] rd;
    logic             irq;
    logic [VecW-1:0]  vec;
    logic [PreW:0]    pre_next;
    logic [WordW-1:0] cur_dec;
    logic [ResW-1:0]  result;

    assign opcode = t_opcode'(i_s_tuser);
    assign offset = i_s_tdata[OffW-1:0];
    assign wdata  = i_s_tdata[OffW +: WordW];
    assign o_s_tready = !r_skid_valid;
    assign accept = i_s_tvalid && o_s_tready;

    assign pre_next = {1'b0, r_prescale} + {{PreW{1'b0}}, 1'b1};
    assign cur_dec  = r_current - {{(WordW-1){1'b0}}, 1'b1};

    always_comb begin
        rd = '0;
        unique case (offset)
            OFF_ID:       rd = {r_unit_id, {(WordW-CfgW){1'b0}}};
            OFF_VERSION:  rd = {{(WordW-CfgW){1'b0}}, r_version};
            OFF_SPURIOUS: rd = {{(WordW-VecW-1){1'b0}}, r_sw_enable, r_spurious};
            OFF_LVT: begin
                rd[VecW-1:0]         = r_lvt_vector;
                rd[LVT_MASK_BIT]     = r_lvt_masked;
                rd[LVT_PERIODIC_BIT] = r_lvt_periodic;
            end
            OFF_INITIAL:  rd = r_initial;
            OFF_CURRENT:  rd = r_current;
            OFF_DIVIDE:   rd = {{(WordW-4){1'b0}}, r_divide};
            default:      rd = '0;
        endcase
        if (opcode != OP_READ) begin
            rd = '0;
        end
    end

    always_comb begin
        n_lvt_vector   = r_lvt_vector;
        n_lvt_masked   = r_lvt_masked;
        n_lvt_periodic = r_lvt_periodic;
        n_initial      = r_initial;
        n_current      = r_current;
        n_divide       = r_divide;
        n_prescale     = r_prescale;
        n_sw_enable    = r_sw_enable;
        n_spurious     = r_spurious;
        n_in_service   = r_in_service;
        n_held         = r_held;
        irq            = 1'b0;
        unique case (opcode)
            OP_WRITE: begin
                unique case (offset)
                    OFF_EOI: begin
                        n_in_service = r_held;
                        n_held       = 1'b0;
                        irq          = r_held;
                    end
                    OFF_SPURIOUS: begin
                        n_spurious  = wdata[VecW-1:0];
                        n_sw_enable = wdata[SW_ENABLE_BIT];
                    end
                    OFF_LVT: begin
                        n_lvt_vector   = wdata[VecW-1:0];
                        n_lvt_masked   = wdata[LVT_MASK_BIT];
                        n_lvt_periodic = wdata[LVT_PERIODIC_BIT];
                    end
                    OFF_INITIAL: begin
                        n_initial  = wdata;
                        n_current  = wdata;
                        n_prescale = '0;
                    end
                    OFF_DIVIDE: begin
                        n_divide   = wdata[3:0] & DIVIDE_BITS;
                        n_prescale = '0;
                    end
                    default: ;
                endcase
            end
            OP_TICK: begin
                if (r_current != '0) begin
                    if (pre_next >= divisor_of(r_divide)) begin
                        n_prescale = '0;
                        n_current  = cur_dec;
                        if (cur_dec == '0) begin
                            if (r_lvt_periodic) begin
                                n_current = r_initial;
                            end
                            if (!r_lvt_masked && r_sw_enable) begin
                                if (!r_in_service) begin
                                    n_in_service = 1'b1;
                                    irq          = 1'b1;
                                end else begin
                                    n_held = 1'b1;
                                end
                            end
                        end
                    end else begin
                        n_prescale = pre_next[PreW-1:0];
                    end
                end
            end
            default: ;
        endcase
        vec = irq ? r_lvt_vector : '0;
    end

    assign result = {vec, irq, rd};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_id      <= '0;
            r_version      <= VERSION_RESET;
            r_lvt_vector   <= '0;
            r_lvt_masked   <= 1'b1;
            r_lvt_periodic <= 1'b0;
            r_initial      <= '0;
            r_current      <= '0;
            r_divide       <= DIVIDE_RESET;
            r_prescale     <= '0;
            r_sw_enable    <= 1'b0;
            r_spurious     <= '1;
            r_in_service   <= 1'b0;
            r_held         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_addr))
                    CFG_UNIT_ID: r_unit_id <= i_cfg_data;
                    CFG_VERSION: r_version <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_lvt_vector   <= n_lvt_vector;
                r_lvt_masked   <= n_lvt_masked;
                r_lvt_periodic <= n_lvt_periodic;
                r_initial      <= n_initial;
                r_current      <= n_current;
                r_divide       <= n_divide;
                r_prescale     <= n_prescale;
                r_sw_enable    <= n_sw_enable;
                r_spurious     <= n_spurious;
                r_in_service   <= n_in_service;
                r_held         <= n_held;
            end
        end
    end

    // output buffer: result register in front, skid register behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || i_m_tready) begin
                r_out_valid  <= r_skid_valid || accept;
                r_skid_valid <= 1'b0;
            end else if (accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_m_tready) begin
            r_out <= r_skid_valid ? r_skid : result;
        end
        if (accept && r_out_valid && !i_m_tready) begin
            r_skid <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OutDataW-ResW){1'b0}}, r_out};

endmodule

// File: tb/timer_check_pkg.sv
package timer_check_pkg;
    import litr_pkg::*;

    typedef struct packed {
        logic [VecW-1:0]  irq_vector;
        logic             irq_valid;
        logic [WordW-1:0] read_data;
    } t_timer_reply;

    class timer_scoreboard;
        logic [CfgW-1:0]  unit_id;
        logic [CfgW-1:0]  version_value;
        logic [VecW-1:0]  lvt_vector;
        logic             lvt_masked;
        logic             lvt_periodic;
        logic [WordW-1:0] init_count;
        logic [WordW-1:0] cur_count;
        logic [3:0]       divide_code;
        logic [PreW-1:0]  prescale;
        logic             sw_enable;
        logic [VecW-1:0]  spur_vector;
        logic             in_service;
        logic             held_expiry;
        t_timer_reply     replies_due[$];
        int unsigned      mismatches;

        function new();
            unit_id       = '0;
            version_value = VERSION_RESET;
            lvt_vector    = '0;
            lvt_masked    = 1'b1;
            lvt_periodic  = 1'b0;
            init_count    = '0;
            cur_count     = '0;
            divide_code   = DIVIDE_RESET;
            prescale      = '0;
            sw_enable     = 1'b0;
            spur_vector   = '1;
            in_service    = 1'b0;
            held_expiry   = 1'b0;
            mismatches    = 0;
        endfunction

        function void set_config(t_cfg_idx idx, logic [CfgW-1:0] val);
            case (idx)
                CFG_UNIT_ID: unit_id = val;
                CFG_VERSION: version_value = val;
                default: ;
            endcase
        endfunction

        function bit idle();
            return replies_due.size() == 0;
        endfunction

        // ticks per count: code bits 3,1,0 select 2..128, all ones selects 1
        function logic [PreW:0] ticks_per_count();
            logic [2:0] sel;
            sel = {divide_code[3], divide_code[1:0]};
            if (sel == 3'b111) begin
                return (PreW+1)'(1);
            end
            return (PreW+1)'(2) << sel;
        endfunction

        function logic [WordW-1:0] register_value(logic [OffW-1:0] off);
            case (off)
                OFF_ID:       return {unit_id, 24'b0};
                OFF_VERSION:  return {24'b0, version_value};
                OFF_SPURIOUS: return {23'b0, sw_enable, spur_vector};
                OFF_LVT:      return {14'b0, lvt_periodic, lvt_masked, 8'b0, lvt_vector};
                OFF_INITIAL:  return init_count;
                OFF_CURRENT:  return cur_count;
                OFF_DIVIDE:   return {28'b0, divide_code & DIVIDE_BITS};
                default:      return '0;
            endcase
        endfunction

        function void note_item(t_opcode op, logic [OffW-1:0] off, logic [WordW-1:0] wdata);
            t_timer_reply rep;
            logic [PreW:0] next_pre;
            rep = '0;
            case (op)
                OP_READ: rep.read_data = register_value(off);
                OP_WRITE: begin
                    case (off)
                        OFF_EOI: begin
                            in_service = 1'b0;
                            if (held_expiry) begin
                                held_expiry = 1'b0;
                                in_service = 1'b1;
                                rep.irq_valid = 1'b1;
                                rep.irq_vector = lvt_vector;
                            end
                        end
                        OFF_SPURIOUS: begin
                            spur_vector = wdata[VecW-1:0];
                            sw_enable = wdata[SW_ENABLE_BIT];
                        end
                        OFF_LVT: begin
                            lvt_vector = wdata[VecW-1:0];
                            lvt_masked = wdata[LVT_MASK_BIT];
                            lvt_periodic = wdata[LVT_PERIODIC_BIT];
                        end
                        OFF_INITIAL: begin
                            init_count = wdata;
                            cur_count = wdata;
                            prescale = '0;
                        end
                        OFF_DIVIDE: begin
                            divide_code = wdata[3:0] & DIVIDE_BITS;
                            prescale = '0;
                        end
                        default: ;
                    endcase
                end
                OP_TICK: begin
                    if (cur_count != 0) begin
                        next_pre = {1'b0, prescale} + 1'b1;
                        if (next_pre >= ticks_per_count()) begin
                            prescale = '0;
                            cur_count = cur_count - 1;
                            if (cur_count == 0) begin
                                if (lvt_periodic) begin
                                    cur_count = init_count;
                                end
                                // expiry only counts when unmasked and enabled
                                if (!lvt_masked && sw_enable) begin
                                    if (!in_service) begin
                                        in_service = 1'b1;
                                        rep.irq_valid = 1'b1;
                                        rep.irq_vector = lvt_vector;
                                    end else begin
                                        held_expiry = 1'b1;
                                    end
                                end
                            end
                        end else begin
                            prescale = next_pre[PreW-1:0];
                        end
                    end
                end
                default: ;
            endcase
            replies_due.push_back(rep);
        endfunction

        function void check_reply(logic [OutDataW-1:0] tdata);
            t_timer_reply want;
            if (replies_due.size() == 0) begin
                $error("result item with nothing expected: %012h", tdata);
                mismatches++;
                return;
            end
            want = replies_due.pop_front();
            if (tdata[31:0] !== want.read_data) begin
                $error("read_data expected %08h got %08h", want.read_data, tdata[31:0]);
                mismatches++;
            end
            if (tdata[32] !== want.irq_valid) begin
                $error("irq_valid expected %0b got %0b", want.irq_valid, tdata[32]);
                mismatches++;
            end
            if (tdata[40:33] !== want.irq_vector) begin
                $error("irq_vector expected %02h got %02h", want.irq_vector, tdata[40:33]);
                mismatches++;
            end
        endfunction
    endclass

endpackage

// File: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import litr_pkg::*;
    import timer_check_pkg::*;

    localparam logic [OffW-1:0] REG_OFFS [8] = '{OFF_ID, OFF_VERSION, OFF_EOI, OFF_SPURIOUS,
                                                 OFF_LVT, OFF_INITIAL, OFF_CURRENT, OFF_DIVIDE};

    logic                clk;
    logic                rst_n    = 1'b0;
    logic                cfg_we   = 1'b0;
    logic [CfgIdxW-1:0]  cfg_addr = '0;
    logic [CfgW-1:0]     cfg_data = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata  = '0;
    logic [1:0]          s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OutDataW-1:0] m_tdata;

    int send_calm = 0;
    int recv_calm = 0;

    timer_scoreboard sb = new();

    local_interrupt_timer_registers i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_addr (cfg_addr),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // wait before an item; now and then a stretch with no waiting at all
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm = $urandom_range(10, 50);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    task automatic write_cfg(input t_cfg_idx idx, input logic [CfgW-1:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        sb.set_config(idx, val);
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic send_item(input t_opcode op, input logic [OffW-1:0] off,
                             input logic [WordW-1:0] wd);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(InDataW-OffW-WordW){1'b0}}, wd, off};
        s_tuser  <= op;
        do @(posedge clk); while (!s_tready);
        sb.note_item(op, off, wd);
    endtask

    task automatic drain_replies();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (!sb.idle());
        repeat (4) @(posedge clk);
    endtask

    task automatic run_directed();
        send_item(OP_READ,  OFF_ID,       32'h0);
        send_item(OP_READ,  OFF_VERSION,  32'hFFFF_FFFF);
        send_item(OP_READ,  OFF_SPURIOUS, 32'h0);
        send_item(OP_READ,  OFF_LVT,      32'h0);
        send_item(OP_READ,  OFF_DIVIDE,   32'h0);
        send_item(OP_READ,  OFF_EOI,      32'h0);
        send_item(OP_READ,  12'hFFF,      32'h0);
        send_item(OP_NONE,  12'hFFF,      32'hFFFF_FFFF);
        send_item(OP_TICK,  12'hFFF,      32'hFFFF_FFFF);   // counter stopped
        send_item(OP_WRITE, OFF_ID,       32'hFFFF_FFFF);   // read-only, ignored
        send_item(OP_WRITE, OFF_CURRENT,  32'hFFFF_FFFF);
        send_item(OP_WRITE, OFF_SPURIOUS, 32'hFFFF_FFFF);
        // periodic, unmasked, vector 0x42, junk in unused bits
        send_item(OP_WRITE, OFF_LVT,      32'hFFFE_FF42);
        send_item(OP_WRITE, OFF_DIVIDE,   32'hFFFF_FFFF);   // divide by one
        send_item(OP_WRITE, OFF_INITIAL,  32'd2);
        send_item(OP_TICK,  12'h000,      32'h0);
        send_item(OP_TICK,  12'h000,      32'h0);           // fires
        send_item(OP_TICK,  12'h000,      32'h0);
        send_item(OP_TICK,  12'h000,      32'h0);           // held while in service
        send_item(OP_TICK,  12'h000,      32'h0);
        send_item(OP_TICK,  12'h000,      32'h0);           // second hold dropped
        send_item(OP_READ,  OFF_CURRENT,  32'h0);
        send_item(OP_WRITE, OFF_EOI,      32'h0);           // held one delivered
        send_item(OP_WRITE, OFF_EOI,      32'h0);
        send_item(OP_WRITE, OFF_DIVIDE,   32'h0);
        send_item(OP_WRITE, OFF_INITIAL,  32'h0);           // stop
        send_item(OP_READ,  OFF_INITIAL,  32'h0);
    endtask

    task automatic random_item(output t_opcode op, output logic [OffW-1:0] off,
                               output logic [WordW-1:0] wd);
        int r;
        r   = $urandom_range(0, 99);
        off = OffW'($urandom);
        wd  = $urandom;
        if (r < 45) begin
            op = OP_TICK;
        end else if (r < 55) begin
            op = OP_WRITE;
            off = OFF_EOI;
        end else if (r < 63) begin
            op = OP_WRITE;
            off = OFF_INITIAL;
            // short counts keep expiries frequent
            if ($urandom_range(0, 7) != 0) begin
                wd = $urandom_range(0, 24);
            end
        end else if (r < 68) begin
            op = OP_WRITE;
            off = OFF_DIVIDE;
            if ($urandom_range(0, 4) < 3) begin
                wd[3:0] = DIVIDE_BITS;
            end
        end else if (r < 73) begin
            op = OP_WRITE;
            off = OFF_LVT;
            wd[LVT_MASK_BIT] = ($urandom_range(0, 3) == 0);
        end else if (r < 77) begin
            op = OP_WRITE;
            off = OFF_SPURIOUS;
            wd[SW_ENABLE_BIT] = ($urandom_range(0, 3) != 0);
        end else if (r < 90) begin
            op = OP_READ;
            off = REG_OFFS[$urandom_range(0, 7)];
        end else if (r < 95) begin
            op = OP_READ;
        end else if (r < 98) begin
            op = OP_WRITE;
        end else begin
            op = OP_NONE;
        end
    endtask

    initial begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever begin
            stall = draw_wait(recv_calm);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            sb.check_reply(m_tdata);
        end
    end

    initial begin
        logic [CfgW-1:0]  id_set [4];
        logic [CfgW-1:0]  ver_set [4];
        t_opcode          op;
        logic [OffW-1:0]  off;
        logic [WordW-1:0] wd;
        id_set  = '{8'h00, 8'hFF, CfgW'($urandom), 8'h5A};
        ver_set = '{8'hFF, 8'h00, CfgW'($urandom), VERSION_RESET};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        for (int phase = 0; phase < 4; phase++) begin
            write_cfg(CFG_UNIT_ID, id_set[phase]);
            write_cfg(CFG_VERSION, ver_set[phase]);
            if (phase == 0) begin
                run_directed();
            end
            repeat (phase == 0 ? 360 : 388) begin
                random_item(op, off, wd);
                send_item(op, off, wd);
            end
            drain_replies();
        end
        if (sb.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
